### rtl/assert_macros.svh
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked while out of reset.
`define BSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bitmap_slot_allocator: assertion failed");

// Checked at every edge, reset included.
`define BSA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bitmap_slot_allocator: assertion failed");

`else

`define BSA_ASSERT(lbl, clk, rst_n, prop)
`define BSA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/bsa_pkg.sv
package bsa_pkg;

    // Most words that a 10-bit slot index can name.
    localparam int MAX_WORDS    = 32;
    localparam int WORD_BITS    = 32;
    localparam int SLOT_W       = 10;
    localparam int BIT_W        = 5;
    localparam int COUNT_W      = 6;

    localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Position of the lowest clear bit; only meaningful for a word that is not full.
    function automatic logic [BIT_W-1:0] first_clear(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

### rtl/bsa_if.sv
interface bsa_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [9:0] slot_index;

    modport source (output valid, output op, output slot_index, input ready);
    modport sink   (input valid, input op, input slot_index, output ready);
endinterface

interface bsa_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] granted_slot;
    logic [1:0] status;

    modport source (output valid, output granted_slot, output status, input ready);
    modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

interface bsa_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bitmap_slot_allocator.sv
// Slot allocator over a bitmap held in a one-port-read RAM (one word of
// 32 slots per entry, bit set = used). Every transaction yields one
// response. For a put, or a get whose search hint points at a word with a
// free slot, the accept cycle issues the RAM read, and the next cycle finds
// or clears the bit, writes the word back and loads the response register.
// A new request is accepted only in idle. A get's scan reads one word per
// cycle, moving past each full word until it finds a free slot or passes
// words_in_use, which answers full. The response register lets a new request
// be accepted while a response waits; that request then holds in its last
// cycle until the response is taken. The bitmap reads as all free after
// reset through per-word valid flops, so no clearing pass is needed.
// words_in_use is saturated to MAP_WORDS and to 32.
`include "assert_macros.svh"

module bitmap_slot_allocator #(
    parameter int MAP_WORDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsa_req_if.sink     i_req,
    bsa_cfg_if.sink     i_cfg,
    bsa_rsp_if.source   o_rsp
);
    import bsa_pkg::*;

    localparam int NWORDS = (MAP_WORDS < MAX_WORDS) ? MAP_WORDS : MAX_WORDS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_GET  = 3'b010,
        S_PUT  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [COUNT_W-1:0]     r_hint, n_hint;
    logic [COUNT_W-1:0]     r_cfg;
    logic [AW-1:0]          r_addr, n_addr;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic                   r_put_ok, n_put_ok;
    logic [NWORDS-1:0]      r_valid, n_valid;
    logic                   r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]      r_out_slot, n_out_slot;
    t_status                r_out_status, n_out_status;

    logic [COUNT_W-1:0]     w_count;
    logic [WORD_BITS-1:0]   w_rd_data;
    logic [WORD_BITS-1:0]   w_word;
    logic [WORD_BITS-1:0]   w_wr_data;
    logic                   w_wr_en;
    logic                   w_can_load;
    logic                   w_req_fire;
    logic                   w_in_range;
    logic [COUNT_W-1:0]     w_hint_next;
    logic [BIT_W-1:0]       w_free_bit;
    logic [COUNT_W-1:0]     w_put_word;

    assign w_count = (r_cfg > COUNT_W'(NWORDS)) ? COUNT_W'(NWORDS) : r_cfg;

    assign i_cfg.ready  = 1'b1;
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_req_fire   = i_req.valid && i_req.ready;
    assign w_can_load   = !r_out_valid || o_rsp.ready;

    assign w_in_range   = {1'b0, i_req.slot_index} < {w_count, 5'b0};
    assign w_hint_next  = r_hint + COUNT_W'(1);
    // A word never written since reset reads as all free.
    assign w_word       = r_valid[r_addr] ? w_rd_data : '0;
    assign w_free_bit   = first_clear(w_word);
    assign w_put_word   = COUNT_W'(r_addr);

    always_comb begin
        n_state      = r_state;
        n_hint       = r_hint;
        n_addr       = r_addr;
        n_bit        = r_bit;
        n_put_ok     = r_put_ok;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        w_wr_en      = 1'b0;
        w_wr_data    = w_word;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    if (i_req.op == OP_GET) begin
                        n_addr  = r_hint[AW-1:0];
                        n_state = S_GET;
                    end else begin
                        n_addr   = i_req.slot_index[BIT_W+AW-1:BIT_W];
                        n_bit    = i_req.slot_index[BIT_W-1:0];
                        n_put_ok = w_in_range;
                        n_state  = S_PUT;
                    end
                end
            end
            S_GET: begin
                if (r_hint >= w_count) begin
                    if (w_can_load) begin
                        n_hint       = w_count;
                        n_out_valid  = 1'b1;
                        n_out_slot   = '0;
                        n_out_status = ST_FULL;
                        n_state      = S_IDLE;
                    end
                end else if (w_word != WORD_FULL) begin
                    if (w_can_load) begin
                        w_wr_en          = 1'b1;
                        w_wr_data        = w_word | (WORD_BITS'(1) << w_free_bit);
                        n_valid[r_addr]  = 1'b1;
                        n_out_valid      = 1'b1;
                        n_out_slot       = {r_hint[BIT_W-1:0], w_free_bit};
                        n_out_status     = ST_OK;
                        n_state          = S_IDLE;
                    end
                end else begin
                    // hint doubles as the scan pointer
                    n_hint = w_hint_next;
                    n_addr = w_hint_next[AW-1:0];
                end
            end
            S_PUT: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = '0;
                    n_state     = S_IDLE;
                    if (r_put_ok) begin
                        w_wr_en         = 1'b1;
                        w_wr_data       = w_word & ~(WORD_BITS'(1) << r_bit);
                        n_valid[r_addr] = 1'b1;
                        n_out_status    = ST_OK;
                        if (r_hint > w_put_word) begin
                            n_hint = w_put_word;
                        end
                    end else begin
                        n_out_status = ST_RANGE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_cfg       <= COUNT_W'(MAX_WORDS);
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hint      <= n_hint;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cfg <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_bit        <= n_bit;
        r_put_ok     <= n_put_ok;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    // Read address follows the next scan position, so data lines up with r_addr.
    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (1'b1),
        .i_rd_addr (n_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted_slot = r_out_slot;
    assign o_rsp.status       = r_out_status;

    `BSA_ASSERT(a_wr_needs_slot, i_clk, i_rst_n, w_wr_en |-> (w_can_load && r_state != S_IDLE))
    `BSA_ASSERT(a_put_only_clears, i_clk, i_rst_n, (w_wr_en && r_state == S_PUT) |-> ((w_wr_data & ~w_word) == '0))
    `BSA_ASSERT(a_get_sets_one, i_clk, i_rst_n, (w_wr_en && r_state == S_GET) |-> ($countones(w_wr_data ^ w_word) == 1))
    `BSA_ASSERT(a_full_hint, i_clk, i_rst_n, (r_state == S_GET && r_hint >= w_count && w_can_load) |=> (r_hint == $past(w_count)))

endmodule

### verif/tb_bitmap_slot_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator;
    import bsa_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int RST_CYCLES = 12;
    localparam int SEG_COUNT  = 12;
    localparam int SEG_ITEMS  = 140;
    localparam int TAIL_WAIT  = 40;       // allowance for the longest get scan
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [SLOT_W-1:0] granted;
        t_status           status;
    } t_grant;

    typedef enum bit {ROW_ITEM, ROW_SETUP} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] words;
        bit                 has_exp;
        logic [SLOT_W-1:0]  granted;
        t_status            status;
    } t_dir_row;

    localparam int DIR_ROWS = 19;

    // Rows with has_exp set carry a result that is plain from the spec;
    // the rest are predicted.
    t_dir_row directed_rows [0:DIR_ROWS-1] = '{
        '{ROW_ITEM,  OP_GET, 10'd0,    6'd0,  1'b1, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_GET, 10'd0,    6'd0,  1'b1, 10'd1, ST_OK},
        '{ROW_ITEM,  OP_PUT, 10'd1023, 6'd0,  1'b1, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_PUT, 10'd1,    6'd0,  1'b1, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_GET, 10'd0,    6'd0,  1'b0, 10'd0, ST_OK},
        '{ROW_SETUP, OP_GET, 10'd0,    6'd0,  1'b0, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_GET, 10'd0,    6'd0,  1'b1, 10'd0, ST_FULL},
        '{ROW_ITEM,  OP_PUT, 10'd0,    6'd0,  1'b1, 10'd0, ST_RANGE},
        '{ROW_ITEM,  OP_PUT, 10'd1023, 6'd0,  1'b1, 10'd0, ST_RANGE},
        '{ROW_SETUP, OP_GET, 10'd0,    6'd63, 1'b0, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_GET, 10'd0,    6'd0,  1'b0, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_PUT, 10'd1023, 6'd0,  1'b1, 10'd0, ST_OK},
        '{ROW_SETUP, OP_GET, 10'd0,    6'd1,  1'b0, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_PUT, 10'd32,   6'd0,  1'b1, 10'd0, ST_RANGE},
        '{ROW_ITEM,  OP_PUT, 10'd31,   6'd0,  1'b1, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_PUT, 10'd0,    6'd0,  1'b1, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_GET, 10'd0,    6'd0,  1'b0, 10'd0, ST_OK},
        '{ROW_ITEM,  OP_GET, 10'd1023, 6'd0,  1'b0, 10'd0, ST_OK},
        '{ROW_SETUP, OP_GET, 10'd0,    6'd32, 1'b0, 10'd0, ST_OK}
    };

    logic [COUNT_W-1:0] seg_words [0:SEG_COUNT-1] = '{
        6'd1, 6'd2, 6'd32, 6'd0, 6'd3, 6'd63, 6'd1, 6'd33, 6'd4, 6'd2, 6'd1, 6'd32
    };

    logic i_clk;
    logic i_rst_n;

    bsa_req_if req_if ();
    bsa_rsp_if rsp_if ();
    bsa_cfg_if cfg_if ();

    bitmap_slot_allocator #(
        .MAP_WORDS (MAX_WORDS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    // Allocator mirror
    logic [WORD_BITS-1:0] used_words [0:MAX_WORDS-1];
    logic [COUNT_W-1:0]   scan_start;
    logic [COUNT_W-1:0]   pool_words;
    logic [SLOT_W-1:0]    held_slots [$];

    t_grant pending_grants [$];
    int     mismatches;
    int     cycle_count;
    int     tx_idle_pct;
    int     rx_idle_pct;

    function automatic t_grant allocate_or_free(logic op, logic [SLOT_W-1:0] slot);
        t_grant r;
        int     count;
        bit     found;
        count     = (int'(pool_words) > MAX_WORDS) ? MAX_WORDS : int'(pool_words);
        r.granted = '0;
        r.status  = ST_OK;
        found     = 1'b0;
        if (op == OP_GET) begin
            for (int w = int'(scan_start); w < count && !found; w++) begin
                for (int b = 0; b < WORD_BITS && !found; b++) begin
                    if (!used_words[w][b]) begin
                        used_words[w][b] = 1'b1;
                        scan_start       = COUNT_W'(w);
                        r.granted        = SLOT_W'(w * WORD_BITS + b);
                        found            = 1'b1;
                    end
                end
            end
            if (found) begin
                held_slots.push_back(r.granted);
            end else begin
                scan_start = COUNT_W'(count);
                r.status   = ST_FULL;
            end
        end else if (int'(slot) < count * WORD_BITS) begin
            used_words[slot[SLOT_W-1:BIT_W]][slot[BIT_W-1:0]] = 1'b0;
            if (scan_start > {1'b0, slot[SLOT_W-1:BIT_W]}) begin
                scan_start = {1'b0, slot[SLOT_W-1:BIT_W]};
            end
        end else begin
            r.status = ST_RANGE;
        end
        return r;
    endfunction

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_grant exp_r;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
                $error("response with nothing outstanding: granted_slot %0d status %0d",
                       rsp_if.granted_slot, rsp_if.status);
                mismatches++;
            end else begin
                exp_r = pending_grants.pop_front();
                if (rsp_if.granted_slot !== exp_r.granted) begin
                    $error("granted_slot: expected %0d, actual %0d",
                           exp_r.granted, rsp_if.granted_slot);
                    mismatches++;
                end
                if (rsp_if.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, rsp_if.status);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [SLOT_W-1:0] slot, bit has_exp, t_grant typed);
        t_grant predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.slot_index <= slot;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = allocate_or_free(op, slot);
        pending_grants.push_back(has_exp ? typed : predicted);
    endtask

    task automatic wait_all_returned();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_pool_words(logic [COUNT_W-1:0] words);
        wait_all_returned();
        repeat (4) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= words;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        pool_words = words;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        t_dir_row           row;
        logic               op;
        logic [SLOT_W-1:0]  slot;
        int                 idx;
        int                 get_pct;

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.op         = OP_GET;
        req_if.slot_index = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        rsp_if.ready      = 1'b0;
        mismatches        = 0;
        cycle_count       = 0;
        tx_idle_pct       = 20;
        rx_idle_pct       = 58;
        for (int w = 0; w < MAX_WORDS; w++) used_words[w] = '0;
        scan_start = '0;
        pool_words = COUNT_W'(32);

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_SETUP) begin
                write_pool_words(row.words);
            end else begin
                send_item(row.op, row.slot, row.has_exp, {row.granted, row.status});
            end
        end

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == 4) begin
                tx_idle_pct = 58;
                rx_idle_pct = 20;
            end else if (seg == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_pool_words(seg_words[seg]);
            for (int i = 0; i < SEG_ITEMS; i++) begin
                if (seg == 1 && i == SEG_ITEMS / 2) begin
                    wait_all_returned();
                end
                // bursts weighted to gets alternate with bursts weighted to frees
                get_pct = ((i / 35) % 2 == 0) ? 75 : 30;
                if ($urandom_range(99) < get_pct) begin
                    op   = OP_GET;
                    slot = SLOT_W'($urandom_range(1023));
                end else begin
                    op = OP_PUT;
                    if (held_slots.size() > 0 && $urandom_range(99) < 80) begin
                        idx  = $urandom_range(held_slots.size() - 1);
                        slot = held_slots[idx];
                        held_slots.delete(idx);
                    end else begin
                        slot = SLOT_W'($urandom_range(1023));
                    end
                end
                send_item(op, slot, 1'b0, '0);
            end
        end

        wait_all_returned();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_if.sv
rtl/bsa_ram.sv
rtl/bitmap_slot_allocator.sv
verif/tb_bitmap_slot_allocator.sv
